/* src/pobb_pkg.sv */
package pobb_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 128;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Controller command bytes and masks
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] LO_MASK    = 8'h0F;
  localparam logic [7:0] HI_MASK    = 8'hF0;
  localparam int         BYTE_BITS  = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef struct packed {
    logic [6:0] col_start;
    logic [5:0] row_start;
    logic [7:0] image_width;
    logic [6:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       source_present;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       last_of_run;
    logic       image_done;
  } out_word_t;

  // One classified column: optional command preamble plus its data byte
  typedef struct packed {
    logic       cmd;
    logic [7:0] page_byte;
    logic [7:0] data;
    logic       done;
  } task_t;

endpackage

/* src/pobb_ram.sv */
module pobb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/pobb_fifo.sv */
module pobb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pobb_pkg::task_t push_data,
  output logic           full,
  input  logic           pop,
  output pobb_pkg::task_t pop_data,
  output logic           empty
);
  import pobb_pkg::*;

  task_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue occupancy beyond depth");
`endif

endmodule

/* src/pobb_front.sv */
module pobb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  pobb_pkg::cfg_t    cfg,
  input  logic              in_push,
  output logic              in_full,
  input  pobb_pkg::in_word_t in_data,
  output logic              q_push,
  output pobb_pkg::task_t   q_data,
  input  logic              q_full
);
  import pobb_pkg::*;

  // Page walk state
  logic [7:0] page_r, page_nxt;
  logic [7:0] col_r, col_nxt;
  logic       first_r, first_nxt;

  // Stage waiting on the line store read
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_cur_r;
  logic [2:0] s1_off_r;
  logic       s1_use_prev_r;
  logic       s1_cmd_r;
  logic [7:0] s1_page_byte_r;
  logic       s1_done_r;

  logic       accept;
  logic [7:0] cur;
  logic [7:0] page_use;
  logic [7:0] next_col;
  logic [7:0] last_page;
  logic [7:0] row_page;
  logic       in_range;
  logic       done;
  logic [7:0] prev;
  logic [7:0] data;

  assign in_full = s1_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = s1_valid_r && !q_full;

  // Classify the incoming column
  always_comb begin
    cur       = in_data.source_present ? in_data.source_byte : 8'h00;
    row_page  = {5'b0, cfg.row_start[5:3]};
    page_use  = (col_r == 8'd0 && first_r) ? row_page : page_r;
    next_col  = col_r + 8'd1;
    last_page = ({2'b0, cfg.row_start} + {1'b0, cfg.image_height}) >> 3;
    in_range  = ({1'b0, col_r} < 9'(MAX_WIDTH));
    done      = 1'b0;
    page_nxt  = page_use;
    col_nxt   = next_col;
    first_nxt = first_r;
    if (next_col == cfg.image_width) begin
      col_nxt = 8'd0;
      if (page_use >= last_page) begin
        done      = 1'b1;
        first_nxt = 1'b1;
        page_nxt  = row_page;
      end else begin
        first_nxt = 1'b0;
        page_nxt  = page_use + 8'd1;
      end
    end
  end

  // Keep the current page in the line store for the next page
  pobb_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && in_range),
    .waddr (col_r[ADDR_W-1:0]),
    .wdata (cur),
    .re    (accept),
    .raddr (col_r[ADDR_W-1:0]),
    .rdata (prev)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r     <= '0;
      col_r      <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        page_r  <= page_nxt;
        col_r   <= col_nxt;
        first_r <= first_nxt;
      end
    end
  end

  // Hold the classified column until the queue takes it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r       <= cur;
      s1_off_r       <= cfg.row_start[2:0];
      s1_use_prev_r  <= !first_r && in_range;
      s1_cmd_r       <= (col_r == 8'd0);
      s1_page_byte_r <= CMD_PAGE + page_use;
      s1_done_r      <= done;
    end
  end

  // Merge current byte with the previous page's spill
  always_comb begin
    data = s1_cur_r << s1_off_r;
    if (s1_off_r != 3'd0 && s1_use_prev_r) begin
      data = data | (prev >> (4'd8 - {1'b0, s1_off_r}));
    end
    q_data.cmd       = s1_cmd_r;
    q_data.page_byte = s1_page_byte_r;
    q_data.data      = data;
    q_data.done      = s1_done_r;
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && q_full) |=> (s1_valid_r && $stable(s1_cur_r) && $stable(s1_done_r)))
    else $error("stalled column lost");
`endif

endmodule

/* src/pobb_back.sv */
module pobb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pobb_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  pobb_pkg::task_t    q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output pobb_pkg::out_word_t out_data
);
  import pobb_pkg::*;

  localparam logic [1:0] STEP_PAGE = 2'd0;
  localparam logic [1:0] STEP_LO   = 2'd1;
  localparam logic [1:0] STEP_HI   = 2'd2;
  localparam logic [1:0] STEP_DATA = 2'd3;

  task_t      task_r;
  logic       busy_r, busy_nxt;
  logic [1:0] step_r, step_nxt;
  out_word_t  out_r;
  logic       ov_r, ov_nxt;

  logic       slot_free;
  logic       emit;
  logic       last_step;
  out_word_t  word;
  logic [7:0] col_ext;

  assign slot_free = !ov_r || out_pop;
  assign emit      = busy_r && slot_free;
  assign last_step = (step_r == STEP_DATA);
  assign q_pop     = !q_empty && (!busy_r || (emit && last_step));
  assign out_empty = !ov_r;
  assign out_data  = out_r;
  assign col_ext   = {1'b0, cfg.col_start};

  // Build the word for the current step
  always_comb begin
    word = '0;
    unique case (step_r)
      STEP_PAGE: begin
        word.out_byte   = task_r.page_byte;
        word.is_command = 1'b1;
      end
      STEP_LO: begin
        word.out_byte   = col_ext & LO_MASK;
        word.is_command = 1'b1;
      end
      STEP_HI: begin
        word.out_byte   = CMD_COL_HI | ((col_ext & HI_MASK) >> 4);
        word.is_command = 1'b1;
      end
      STEP_DATA: begin
        word.out_byte    = task_r.data;
        word.last_of_run = 1'b1;
        word.image_done  = task_r.done;
      end
      default: word = '0;
    endcase
  end

  // Advance the sequencer
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = q_data.cmd ? STEP_PAGE : STEP_DATA;
    end else if (emit && last_step) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      step_nxt = step_r + 2'd1;
    end
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_DATA;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      task_r <= q_data;
    end
    if (emit) begin
      out_r <= word;
    end
  end

`ifndef SYNTH
  a_cmd_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r != STEP_DATA) |-> task_r.cmd)
    else $error("command step on a column without preamble");
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_step) |=> (ov_r && out_r.last_of_run && !out_r.is_command))
    else $error("data word not marked last");
`endif

endmodule

/* src/page_oled_bitmap_blit.sv */
// A column passes the front stage, queue, task and output registers. Throughput: one
// column per cycle in unless the queue is full; one word per cycle out while popped. A
// column that opens a page emits three commands plus data, others only their data. The
// output sequencer and the four-entry queue in front of it set the sustained rate.
// Reset: synchronous, active low; only control and config registers take defaults; the
// line store is not cleared and is valid only for columns written on the previous page.
module page_oled_bitmap_blit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  pobb_pkg::in_word_t                 in_data,
  output logic                               out_empty,
  input  logic                               out_pop,
  output pobb_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic [pobb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [7:0]                         cfg_wdata
);
  import pobb_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_empty;
  task_t q_in, q_out;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_start    <= 7'd0;
      cfg_r.row_start    <= 6'd0;
      cfg_r.image_width  <= 8'd128;
      cfg_r.image_height <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COL_START:    cfg_r.col_start    <= cfg_wdata[6:0];
        REG_ROW_START:    cfg_r.row_start    <= cfg_wdata[5:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  pobb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_full  (q_full)
  );

  pobb_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  pobb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
